### rtl/fmso_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions of the fm sine oscillator
package fmso_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CHUNK_W    = 13;
  localparam int unsigned CHUNK_MAX  = 4096;

  localparam logic [CHUNK_W-1:0] CHUNK_LEN_RST   = 13'd512;
  localparam logic [15:0]        OUT_GAIN_RST    = 16'd500;
  localparam logic [15:0]        BASE_FREQ_RST   = 16'd1100;
  localparam logic [15:0]        FREQ_DEV_RST    = 16'd1000;
  localparam logic [15:0]        MOD_DIVISOR_RST = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHUNK_LEN   = 3'd0,
    REG_OUT_GAIN    = 3'd1,
    REG_BASE_FREQ   = 3'd2,
    REG_FREQ_DEV    = 3'd3,
    REG_MOD_DIVISOR = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk_len;
    logic [15:0]        out_gain;
    logic [15:0]        base_freq;
    logic [15:0]        freq_dev;
    logic [15:0]        mod_divisor;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic wide;
  } div_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] base_q(input logic [15:0] b,
                                                input int unsigned frac);
    logic [63:0] v;
    v = {48'd0, b} << frac;
    return sat32($signed(v));
  endfunction

endpackage

### rtl/fmso_cfg.sv
`timescale 1ns / 1ps
// configuration register file of the fm sine oscillator
module fmso_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fmso_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fmso_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output fmso_pkg::cfg_t                      cfg_o
);

  fmso_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chunk_len   <= fmso_pkg::CHUNK_LEN_RST;
      cfg_q.out_gain    <= fmso_pkg::OUT_GAIN_RST;
      cfg_q.base_freq   <= fmso_pkg::BASE_FREQ_RST;
      cfg_q.freq_dev    <= fmso_pkg::FREQ_DEV_RST;
      cfg_q.mod_divisor <= fmso_pkg::MOD_DIVISOR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fmso_pkg::REG_CHUNK_LEN:   cfg_q.chunk_len   <= cfg_data_i[fmso_pkg::CHUNK_W-1:0];
        fmso_pkg::REG_OUT_GAIN:    cfg_q.out_gain    <= cfg_data_i;
        fmso_pkg::REG_BASE_FREQ:   cfg_q.base_freq   <= cfg_data_i;
        fmso_pkg::REG_FREQ_DEV:    cfg_q.freq_dev    <= cfg_data_i;
        fmso_pkg::REG_MOD_DIVISOR: cfg_q.mod_divisor <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

### rtl/fmso_div.sv
`timescale 1ns / 1ps
// shared restoring divider, one quotient bit per cycle
module fmso_div #(
  parameter int unsigned FRAC_BITS = fmso_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fmso_pkg::div_req_t req_i,
  input  logic [31:0]        dividend_i,
  input  logic [31:0]        divisor_i,
  output logic               done_o,
  output logic [32:0]        quot_o
);

  localparam int unsigned DW = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   rem_q;
  logic [DW-1:0] quo_q;
  logic [31:0]   dvs_q;

  logic [32:0] rem_sh;
  logic [33:0] diff;
  logic        ge;

  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign ge     = !diff[33];
  assign done_o = done_q;
  assign quot_o = quo_q[32:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.wide ? CW'(DW) : CW'(32);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= DW'(dividend_i) << FRAC_BITS;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : rem_sh[31:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(req_i.start))
    else $error("divider busy without a start");

endmodule

### rtl/fm_sine_oscillator.sv
`timescale 1ns / 1ps
// top level of the fm sine oscillator: sequencer, state and output register
// Each input transaction yields one 16-bit sample on the output stream; a set
// restart bit reloads the oscillator state first. The state is Q15.16 at the
// default FRAC_BITS, and the first sample of each chunk also runs the modulator
// step before the carrier step. The shared restoring divider produces one
// quotient bit per cycle: 32 steps for the modulator velocity and 32 + FRAC_BITS
// steps for the carrier velocity. A finished sample waits in the output register
// while the next transaction is already being worked on.
module fm_sine_oscillator #(
  parameter int unsigned FRAC_BITS = fmso_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [0] restart
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // [15:0] sample
  output logic                            m_axis_tlast,  // chunk_last
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fmso_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fmso_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam logic signed [31:0] ONE32  = 32'(64'd1 << FRAC_BITS);
  localparam logic signed [63:0] ONE64  = 64'(64'd1 << FRAC_BITS);
  localparam logic signed [48:0] RND49  = 49'((64'd1 << FRAC_BITS) - 64'd1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD_ADD,
    S_MOD_GO,
    S_MOD_WAIT,
    S_MOD_MUL,
    S_MOD_DIVSR,
    S_CAR_ADD,
    S_CAR_GO,
    S_CAR_WAIT,
    S_OUT
  } state_e;

  fmso_pkg::cfg_t     cfg;
  fmso_pkg::div_req_t div_req;
  logic               div_done;
  logic [32:0]        div_quot;

  state_e                  state_q;
  logic signed [31:0]      cpos_q, cvel_q, mpos_q, mvel_q, cdiv_q;
  logic [11:0]             chunk_pos_q;
  logic                    div_neg_q;
  logic signed [48:0]      mul_q;
  logic signed [15:0]      samp_q;
  logic                    out_valid_q;
  logic [15:0]             out_sample_q;
  logic                    out_last_q;

  logic                    in_fire;
  logic                    restart;
  logic [31:0]             div_dividend;
  logic [31:0]             div_divisor;
  logic signed [31:0]      div_src;
  logic [15:0]             md;
  logic signed [31:0]      car_divisor;
  logic signed [33:0]      quot_s;
  logic [15:0]             mul_a;
  logic signed [31:0]      mul_b;
  logic signed [48:0]      mul_p;
  logic signed [63:0]      f_sum;
  logic signed [63:0]      f_clamp;
  logic signed [48:0]      s_shift;
  logic signed [15:0]      s_sat;
  logic [12:0]             chunk_lim;
  logic                    last;
  logic                    out_free;

  fmso_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fmso_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign restart       = s_axis_tdata[0];

  // divider operands
  assign md          = (cfg.mod_divisor == 16'd0) ? 16'd1 : cfg.mod_divisor;
  assign car_divisor = (cdiv_q < ONE32) ? ONE32 : cdiv_q;
  assign div_src     = (state_q == S_MOD_GO) ? mpos_q : cpos_q;
  assign div_dividend = div_src[31] ? (~div_src + 32'd1) : div_src;
  assign div_divisor  = (state_q == S_MOD_GO) ? {16'd0, md} : car_divisor;
  assign div_req.start = (state_q == S_MOD_GO) || (state_q == S_CAR_GO);
  assign div_req.wide  = (state_q == S_CAR_GO);
  assign quot_s = div_neg_q ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

  // shared multiplier
  assign mul_a = (state_q == S_MOD_MUL) ? cfg.freq_dev : cfg.out_gain;
  assign mul_b = (state_q == S_MOD_MUL) ? mvel_q : cpos_q;
  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  // carrier divisor from the modulator
  assign f_sum   = $signed(64'({48'd0, cfg.base_freq}) << FRAC_BITS)
                 + 64'(mul_q);
  assign f_clamp = (f_sum < ONE64) ? ONE64 : f_sum;

  // sample, truncated toward zero and saturated
  assign s_shift = (mul_q + (mul_q[48] ? RND49 : 49'sd0)) >>> FRAC_BITS;
  assign s_sat   = (s_shift > 49'sd32767)  ? 16'sh7FFF :
                   (s_shift < -49'sd32768) ? 16'sh8000 : s_shift[15:0];

  // chunk bookkeeping
  assign chunk_lim = (cfg.chunk_len == 13'd0) ? 13'd1 :
                     (cfg.chunk_len > 13'(fmso_pkg::CHUNK_MAX)) ?
                     13'(fmso_pkg::CHUNK_MAX) : cfg.chunk_len;
  assign last      = ({1'b0, chunk_pos_q} + 13'd1) >= chunk_lim;
  assign out_free  = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cpos_q      <= '0;
      cvel_q      <= ONE32;
      mpos_q      <= '0;
      mvel_q      <= ONE32;
      cdiv_q      <= fmso_pkg::base_q(fmso_pkg::BASE_FREQ_RST, FRAC_BITS);
      chunk_pos_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (restart) begin
              cpos_q      <= '0;
              cvel_q      <= ONE32;
              mpos_q      <= '0;
              mvel_q      <= ONE32;
              cdiv_q      <= fmso_pkg::base_q(cfg.base_freq, FRAC_BITS);
              chunk_pos_q <= '0;
            end
            state_q <= (restart || chunk_pos_q == 12'd0) ? S_MOD_ADD : S_CAR_ADD;
          end
        end
        S_MOD_ADD: begin
          mpos_q  <= fmso_pkg::sat32(64'(mpos_q) + 64'(mvel_q));
          state_q <= S_MOD_GO;
        end
        S_MOD_GO: begin
          state_q <= S_MOD_WAIT;
        end
        S_MOD_WAIT: begin
          if (div_done) begin
            mvel_q  <= fmso_pkg::sat32(64'(mvel_q) - 64'(quot_s));
            state_q <= S_MOD_MUL;
          end
        end
        S_MOD_MUL: begin
          state_q <= S_MOD_DIVSR;
        end
        S_MOD_DIVSR: begin
          cdiv_q  <= fmso_pkg::sat32(f_clamp);
          state_q <= S_CAR_ADD;
        end
        S_CAR_ADD: begin
          cpos_q  <= fmso_pkg::sat32(64'(cpos_q) + 64'(cvel_q));
          state_q <= S_CAR_GO;
        end
        S_CAR_GO: begin
          state_q <= S_CAR_WAIT;
        end
        S_CAR_WAIT: begin
          if (div_done) begin
            cvel_q  <= fmso_pkg::sat32(64'(cvel_q) - 64'(quot_s));
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            chunk_pos_q <= last ? 12'd0 : (chunk_pos_q + 12'd1);
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_req.start) begin
      div_neg_q <= div_src[31];
    end
    if (state_q == S_MOD_MUL || state_q == S_CAR_GO) begin
      mul_q <= mul_p;
    end
    if (state_q == S_CAR_WAIT && div_done) begin
      samp_q <= s_sat;
    end
    if (state_q == S_OUT && out_free) begin
      out_sample_q <= samp_q;
      out_last_q   <= last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_sample_q;
  assign m_axis_tlast  = out_last_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_MOD_ADD || state_q == S_CAR_ADD))
    else $error("accepted transaction did not start a step");

  a_car_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CAR_WAIT && div_done) |=> state_q == S_OUT)
    else $error("carrier division result not taken");

  a_out_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> (m_axis_tvalid && state_q == S_IDLE))
    else $error("finished sample not placed in output register");

endmodule

### dv/fmso_checker.sv
`timescale 1ns / 1ps
// checker of the fm sine oscillator: predicts every sample and compares it with the output stream
module fmso_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [0] restart
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [15:0]                     m_axis_tdata,  // [15:0] sample
  input  logic                            m_axis_tlast,  // chunk_last
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [fmso_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fmso_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              n_fail_o,
  output int                              n_pending_o
);

  localparam longint ONE_Q     = 64'sd1 << fmso_pkg::FRAC_BITS_DEF;
  localparam longint LEN_LIMIT = longint'(fmso_pkg::CHUNK_MAX);

  typedef struct {
    logic [15:0] sample;
    logic        last;
  } sample_t;

  sample_t expected_samples[$];
  sample_t head;
  sample_t fresh;

  // register shadow
  longint len_r, gain_r, base_r, dev_r, mdiv_r;

  // oscillator state
  int osc_pos, osc_vel, lfo_pos, lfo_vel, osc_div;
  int chunk_cnt;

  function automatic int clamp_q(input longint v);
    int r;
    if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else r = int'(v);
    return r;
  endfunction

  function automatic void reload_osc();
    osc_pos   = 0;
    osc_vel   = int'(ONE_Q);
    lfo_pos   = 0;
    lfo_vel   = int'(ONE_Q);
    osc_div   = clamp_q(base_r * ONE_Q);
    chunk_cnt = 0;
  endfunction

  function automatic sample_t next_sample(input logic restart);
    sample_t r;
    longint len, md, f, dv, s;
    len = len_r;
    if (len == 0) len = 1;
    if (len > LEN_LIMIT) len = LEN_LIMIT;
    if (restart) reload_osc();
    // modulator step at chunk start
    if (chunk_cnt == 0) begin
      md = (mdiv_r == 0) ? 64'sd1 : mdiv_r;
      lfo_pos = clamp_q(longint'(lfo_pos) + longint'(lfo_vel));
      lfo_vel = clamp_q(longint'(lfo_vel) - longint'(lfo_pos) / md);
      f = base_r * ONE_Q + dev_r * longint'(lfo_vel);
      if (f < ONE_Q) f = ONE_Q;
      osc_div = clamp_q(f);
    end
    osc_pos = clamp_q(longint'(osc_pos) + longint'(osc_vel));
    dv = longint'(osc_div);
    if (dv < ONE_Q) dv = ONE_Q;
    osc_vel = clamp_q(longint'(osc_vel) - (longint'(osc_pos) * ONE_Q) / dv);
    s = (gain_r * longint'(osc_pos)) / ONE_Q;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    r.sample = 16'(s);
    if (longint'(chunk_cnt) + 1 >= len) begin
      r.last    = 1'b1;
      chunk_cnt = 0;
    end else begin
      r.last    = 1'b0;
      chunk_cnt = (chunk_cnt + 1) & 32'hFFF;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_r  = longint'(fmso_pkg::CHUNK_LEN_RST);
      gain_r = longint'(fmso_pkg::OUT_GAIN_RST);
      base_r = longint'(fmso_pkg::BASE_FREQ_RST);
      dev_r  = longint'(fmso_pkg::FREQ_DEV_RST);
      mdiv_r = longint'(fmso_pkg::MOD_DIVISOR_RST);
      reload_osc();
      expected_samples.delete();
      n_fail_o    = 0;
      n_pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          fmso_pkg::REG_CHUNK_LEN:
            len_r  = longint'(cfg_data_i[fmso_pkg::CHUNK_W-1:0]);
          fmso_pkg::REG_OUT_GAIN:    gain_r = longint'(cfg_data_i);
          fmso_pkg::REG_BASE_FREQ:   base_r = longint'(cfg_data_i);
          fmso_pkg::REG_FREQ_DEV:    dev_r  = longint'(cfg_data_i);
          fmso_pkg::REG_MOD_DIVISOR: mdiv_r = longint'(cfg_data_i);
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          n_fail_o++;
          if (n_fail_o <= 10)
            $display("checker: unexpected sample %0d last %0b at %0t",
                     $signed(m_axis_tdata), m_axis_tlast, $realtime);
        end else begin
          head = expected_samples.pop_front();
          if (m_axis_tdata !== head.sample || m_axis_tlast !== head.last) begin
            n_fail_o++;
            if (n_fail_o <= 10)
              $display("checker: mismatch at %0t: sample exp %0d got %0d, last exp %0b got %0b",
                       $realtime, $signed(head.sample), $signed(m_axis_tdata),
                       head.last, m_axis_tlast);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        fresh = next_sample(s_axis_tdata[0]);
        expected_samples.push_back(fresh);
      end
      n_pending_o = expected_samples.size();
    end
  end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// testbench top of the fm sine oscillator: clock, reset, stimulus and verdict
module testbench;

  localparam logic [fmso_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [15:0]                     m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [fmso_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [fmso_pkg::CFG_DATA_W-1:0] cfg_data_i;

  int n_fail;
  int n_pending;
  int send_idle_pct = 25;
  int recv_idle_pct = 57;
  int hold_cycles   = 0;

  fm_sine_oscillator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  fmso_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .n_fail_o      (n_fail),
    .n_pending_o   (n_pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #10_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // sample receiver with random stalls and a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_item(input logic restart);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, restart};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (n_pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [fmso_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic shuffle_config();
    logic [15:0] len;
    case ($urandom_range(9))
      0: len = 16'd0;
      1: len = 16'd4096;
      2: len = 16'($urandom);
      3: len = 16'd1;
      default: len = 16'($urandom_range(24, 2));
    endcase
    write_reg(fmso_pkg::REG_CHUNK_LEN, len);
    write_reg(fmso_pkg::REG_OUT_GAIN,
              ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom));
    write_reg(fmso_pkg::REG_BASE_FREQ,
              ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom));
    write_reg(fmso_pkg::REG_FREQ_DEV,
              ($urandom_range(4) == 0) ? 16'hFFFF : 16'($urandom));
    write_reg(fmso_pkg::REG_MOD_DIVISOR,
              ($urandom_range(4) == 0) ? 16'($urandom_range(1)) : 16'($urandom));
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = fmso_pkg::REG_CHUNK_LEN;
    cfg_data_i    = 16'd0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings, with and without restart
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    wait_idle();

    // zero chunk length and zero modulator divisor
    write_reg(fmso_pkg::REG_CHUNK_LEN, 16'd0);
    write_reg(fmso_pkg::REG_MOD_DIVISOR, 16'd0);
    repeat (3) send_item(1'b0);
    wait_idle();

    // oversized chunk, full gain, divisor clamp and overflow
    write_reg(fmso_pkg::REG_CHUNK_LEN, 16'hFFFF);
    write_reg(fmso_pkg::REG_OUT_GAIN, 16'hFFFF);
    write_reg(fmso_pkg::REG_BASE_FREQ, 16'd1);
    write_reg(fmso_pkg::REG_FREQ_DEV, 16'hFFFF);
    write_reg(fmso_pkg::REG_MOD_DIVISOR, 16'd1);
    send_item(1'b1);
    repeat (3) send_item(1'b0);
    wait_idle();
    write_reg(fmso_pkg::REG_BASE_FREQ, 16'hFFFF);
    write_reg(fmso_pkg::REG_FREQ_DEV, 16'd0);
    send_item(1'b1);
    send_item(1'b0);
    wait_idle();

    // chunk length lowered mid-chunk
    write_reg(fmso_pkg::REG_CHUNK_LEN, 16'd8);
    write_reg(fmso_pkg::REG_BASE_FREQ, 16'd0);
    write_reg(fmso_pkg::REG_OUT_GAIN, 16'd0);
    send_item(1'b1);
    repeat (4) send_item(1'b0);
    wait_idle();
    write_reg(fmso_pkg::REG_CHUNK_LEN, 16'd2);
    write_reg(REG_UNUSED, 16'hFFFF);
    write_reg(fmso_pkg::REG_OUT_GAIN, 16'd1000);
    repeat (3) send_item(1'b0);

    for (int seg = 0; seg < 10; seg++) begin
      wait_idle();
      if (seg == 3) begin
        send_idle_pct = 57;
        recv_idle_pct = 25;
      end
      if (seg == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      shuffle_config();
      for (int k = 0; k < 98; k++) begin
        send_item($urandom_range(39) == 0);
        if (seg == 6 && k == 2) hold_cycles = 600;
      end
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (n_fail == 0 && n_pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
